// ----- rtl/spbpf_pkg.sv -----
// Shared types, constants and the log-weight helper for the spectrum bar block.
// No dependencies; compiled first.
package spbpf_pkg;

    localparam int MAX_BANDS_DEF  = 256;
    localparam int LEVEL_BITS_DEF = 16;

    localparam int BIN_W   = 16;
    localparam int IDX_W   = 8;
    localparam int SHOWN_W = 15;
    localparam int ROW_W   = 12;
    localparam int SUM_W   = 20;
    localparam int W_W     = 16;
    localparam int BIN_CNT_W = 4;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam int BPB_W    = 5;
    localparam int BCOUNT_W = 9;
    localparam int DECAY_W  = 16;
    localparam int PANE_W   = 12;

    localparam logic [BPB_W-1:0]    BPB_RST    = 5'd3;
    localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 9'd80;
    localparam logic [DECAY_W-1:0]  DECAY_RST  = 16'd492;
    localparam logic [PANE_W-1:0]   PANE_RST   = 12'd600;

    localparam int BPB_MAX     = 16;
    localparam int LEVEL_CLAMP = 22938;
    localparam int ONE_Q14     = 16384;
    localparam int ROW_OFFSET  = 23;
    localparam int ROW_BIAS    = ROW_OFFSET * ONE_Q14;
    localparam int ROW_MIN     = 5;
    localparam int ROW_CLAMPED = 7;
    localparam int ROW_SHIFT   = 22;
    localparam logic [63:0] LN2_Q32 = 64'd2977044472;

    typedef enum logic [1:0] {
        REG_BINS_PER_BAND = 2'd0,
        REG_BAND_COUNT    = 2'd1,
        REG_DECAY_STEP    = 2'd2,
        REG_PANE_HEIGHT   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_LEVEL,
        ST_PEAK,
        ST_PROD,
        ST_QUOT,
        ST_DONE
    } t_state;

    // ln(n) in Q3.13 via log2 by repeated squaring; used on constants only
    function automatic logic [W_W-1:0] ln_q13(input int unsigned n);
        int unsigned k;
        int unsigned frac;
        logic [63:0] x;
        logic [63:0] lg;
        int          i;
        k    = 0;
        frac = 0;
        for (i = 0; i < 31; i++) begin
            if ((n >> (i + 1)) != 0) k = i + 1;
        end
        x = (64'(n) << 30) >> k;
        for (i = 1; i <= 20; i++) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
                x    = x >> 1;
                frac = frac | (32'd1 << (20 - i));
            end
        end
        lg = (64'(k) << 20) | 64'(frac);
        return W_W'((lg * LN2_Q32 + (64'd1 << 38)) >> 39);
    endfunction

endpackage

// ----- rtl/spbpf_in_if.sv -----
// Input channel: one spectrum bin per transfer.
// Depends on spbpf_pkg.
interface spbpf_in_if;
    logic                           valid;
    logic                           ready;
    logic [spbpf_pkg::BIN_W-1:0]    bin_value;
    logic                           frame_start;

    modport source (output valid, bin_value, frame_start, input ready);
    modport sink   (input valid, bin_value, frame_start, output ready);
endinterface

// ----- rtl/spbpf_out_if.sv -----
// Output channel: one bar result per transfer.
// Depends on spbpf_pkg.
interface spbpf_out_if;
    logic                           valid;
    logic                           ready;
    logic [spbpf_pkg::IDX_W-1:0]    band_index;
    logic [spbpf_pkg::SHOWN_W-1:0]  shown_level;
    logic [spbpf_pkg::ROW_W-1:0]    bar_top_row;
    logic                           last_band;

    modport source (output valid, band_index, shown_level, bar_top_row, last_band,
                    input ready);
    modport sink   (input valid, band_index, shown_level, bar_top_row, last_band,
                    output ready);
endinterface

// ----- rtl/spectrum_bar_peak_falloff.sv -----
// Spectrum bar levels: band summing, log weighting, clamp, peak hold with falloff and bar top row.
// Depends on spbpf_pkg, spbpf_in_if, spbpf_out_if.
//
//   channel  | dir | payload                                        | handshake
//   i_bin    | in  | bin_value, frame_start                         | valid/ready
//   o_bar    | out | band_index, shown_level, bar_top_row, last_band| valid/ready
//   APB      | in  | bins_per_band, band_count, decay_step, pane_h  | psel/penable
//
// A bin that does not close a band is taken in ST_IDLE, which it does not leave.
// A bin that closes a band runs these steps: weight/peak memory read, multiply, clamp,
// peak read-modify-write, row product, quotient, row finish into the output register.
// After reset a clearing pass zeroes every entry of the peak memory; no bins are taken during it.
// A held output stalls the band pipeline only in its last step.
module spectrum_bar_peak_falloff #(
    parameter int MAX_BANDS  = spbpf_pkg::MAX_BANDS_DEF,
    parameter int LEVEL_BITS = spbpf_pkg::LEVEL_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    spbpf_in_if.sink                        i_bin,
    spbpf_out_if.source                     o_bar,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [spbpf_pkg::PADDR_W-1:0]   paddr,
    input  logic [spbpf_pkg::PDATA_W-1:0]   pwdata,
    output logic [spbpf_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);

    localparam int BAND_W = $clog2(MAX_BANDS);
    localparam int CNT_W  = $clog2(MAX_BANDS + 1);
    localparam int CMP_W  = (CNT_W > spbpf_pkg::BCOUNT_W) ? CNT_W : spbpf_pkg::BCOUNT_W;
    localparam int PW     = ((LEVEL_BITS > spbpf_pkg::DECAY_W) ? LEVEL_BITS
                                                                : spbpf_pkg::DECAY_W) + 1;
    localparam int PROD_W = spbpf_pkg::SUM_W + spbpf_pkg::W_W;
    localparam int S_W    = 31;
    localparam int Q_W    = 17;
    localparam int R_W    = 18;

    // configuration
    logic [spbpf_pkg::BPB_W-1:0]    r_bpb;
    logic [spbpf_pkg::BCOUNT_W-1:0] r_band_count;
    logic [spbpf_pkg::DECAY_W-1:0]  r_decay;
    logic [spbpf_pkg::PANE_W-1:0]   r_pane;
    logic                           w_cfg_wr;
    spbpf_pkg::t_reg_idx            w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = spbpf_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpb        <= spbpf_pkg::BPB_RST;
            r_band_count <= spbpf_pkg::BCOUNT_RST;
            r_decay      <= spbpf_pkg::DECAY_RST;
            r_pane       <= spbpf_pkg::PANE_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                spbpf_pkg::REG_BINS_PER_BAND: r_bpb <= pwdata[spbpf_pkg::BPB_W-1:0];
                spbpf_pkg::REG_BAND_COUNT:    r_band_count <= pwdata[spbpf_pkg::BCOUNT_W-1:0];
                spbpf_pkg::REG_DECAY_STEP:    r_decay <= pwdata[spbpf_pkg::DECAY_W-1:0];
                spbpf_pkg::REG_PANE_HEIGHT:   r_pane <= pwdata[spbpf_pkg::PANE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            spbpf_pkg::REG_BINS_PER_BAND: prdata = spbpf_pkg::PDATA_W'(r_bpb);
            spbpf_pkg::REG_BAND_COUNT:    prdata = spbpf_pkg::PDATA_W'(r_band_count);
            spbpf_pkg::REG_DECAY_STEP:    prdata = spbpf_pkg::PDATA_W'(r_decay);
            spbpf_pkg::REG_PANE_HEIGHT:   prdata = spbpf_pkg::PDATA_W'(r_pane);
            default:                      prdata = '0;
        endcase
    end

    // state machine
    spbpf_pkg::t_state r_state, n_state;
    logic [BAND_W-1:0] r_clr;
    logic              w_clr_last;
    logic              w_accept;
    logic              w_launch;
    logic              w_out_free;
    logic              w_clr_we;
    logic              w_pk_we;
    logic              w_load_out;

    assign w_clr_last = (r_clr == BAND_W'(MAX_BANDS - 1));
    assign w_accept   = i_bin.valid && i_bin.ready;
    assign w_out_free = !o_bar.valid || o_bar.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spbpf_pkg::ST_CLEAR: if (w_clr_last) n_state = spbpf_pkg::ST_IDLE;
            spbpf_pkg::ST_IDLE:  if (w_launch) n_state = spbpf_pkg::ST_MUL;
            spbpf_pkg::ST_MUL:   n_state = spbpf_pkg::ST_LEVEL;
            spbpf_pkg::ST_LEVEL: n_state = spbpf_pkg::ST_PEAK;
            spbpf_pkg::ST_PEAK:  n_state = spbpf_pkg::ST_PROD;
            spbpf_pkg::ST_PROD:  n_state = spbpf_pkg::ST_QUOT;
            spbpf_pkg::ST_QUOT:  n_state = spbpf_pkg::ST_DONE;
            spbpf_pkg::ST_DONE:  if (w_out_free) n_state = spbpf_pkg::ST_IDLE;
            default:             n_state = spbpf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_bin.ready = (r_state == spbpf_pkg::ST_IDLE);
        w_clr_we    = (r_state == spbpf_pkg::ST_CLEAR);
        w_pk_we     = (r_state == spbpf_pkg::ST_PEAK);
        w_load_out  = (r_state == spbpf_pkg::ST_DONE) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spbpf_pkg::ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (w_clr_we) r_clr <= r_clr + 1'b1;
        end
    end

    // band accumulation
    logic [CNT_W-1:0]                  r_band_cnt;
    logic [spbpf_pkg::BIN_CNT_W-1:0]   r_bin_cnt;
    logic [spbpf_pkg::SUM_W-1:0]       r_acc;
    logic [CMP_W-1:0]                  w_nb_ext;
    logic [CNT_W-1:0]                  w_nb;
    logic [spbpf_pkg::BPB_W-1:0]       w_bpb;
    logic [CNT_W-1:0]                  w_bc;
    logic [spbpf_pkg::BIN_CNT_W-1:0]   w_bn;
    logic [spbpf_pkg::SUM_W-1:0]       w_acc;
    logic                              w_skip;
    logic [spbpf_pkg::SUM_W-1:0]       w_acc_nx;
    logic [spbpf_pkg::BPB_W-1:0]       w_bn_nx;
    logic                              w_close;
    logic                              w_last;

    always_comb begin
        if (CMP_W'(r_band_count) > CMP_W'(MAX_BANDS)) w_nb_ext = CMP_W'(MAX_BANDS);
        else w_nb_ext = CMP_W'(r_band_count);
        w_nb = CNT_W'(w_nb_ext);
        if (r_bpb == '0) w_bpb = spbpf_pkg::BPB_W'(1);
        else if (r_bpb > spbpf_pkg::BPB_W'(spbpf_pkg::BPB_MAX))
            w_bpb = spbpf_pkg::BPB_W'(spbpf_pkg::BPB_MAX);
        else w_bpb = r_bpb;
        w_bc     = i_bin.frame_start ? '0 : r_band_cnt;
        w_bn     = i_bin.frame_start ? '0 : r_bin_cnt;
        w_acc    = i_bin.frame_start ? '0 : r_acc;
        w_skip   = (w_bc >= w_nb);
        w_acc_nx = w_acc + spbpf_pkg::SUM_W'(i_bin.bin_value);
        w_bn_nx  = spbpf_pkg::BPB_W'(w_bn) + 1'b1;
        w_close  = (w_bn_nx >= w_bpb);
        w_last   = ((CNT_W + 1)'(w_bc) + 1'b1) == (CNT_W + 1)'(w_nb);
    end

    assign w_launch = w_accept && !w_skip && w_close;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_cnt <= '0;
            r_bin_cnt  <= '0;
            r_acc      <= '0;
        end else if (w_accept) begin
            if (w_skip) begin
                r_band_cnt <= w_bc;
                r_bin_cnt  <= w_bn;
                r_acc      <= w_acc;
            end else if (w_close) begin
                r_band_cnt <= w_bc + 1'b1;
                r_bin_cnt  <= '0;
                r_acc      <= '0;
            end else begin
                r_band_cnt <= w_bc;
                r_bin_cnt  <= w_bn_nx[spbpf_pkg::BIN_CNT_W-1:0];
                r_acc      <= w_acc_nx;
            end
        end
    end

    // weight table and peak memory
    logic [spbpf_pkg::W_W-1:0] w_rom [MAX_BANDS];
    logic [LEVEL_BITS-1:0]     r_peak_mem [MAX_BANDS];

    for (genvar g = 0; g < MAX_BANDS; g++) begin : g_rom
        assign w_rom[g] = spbpf_pkg::ln_q13(32'(g) + 32'd2);
    end

    logic [BAND_W-1:0]          w_rd_addr;
    logic [BAND_W-1:0]          r_band;
    logic [spbpf_pkg::SUM_W-1:0] r_sum;
    logic                       r_last;
    logic [spbpf_pkg::W_W-1:0]  r_weight;
    logic [LEVEL_BITS-1:0]      r_peak_q;
    logic [BAND_W-1:0]          w_wa;
    logic [LEVEL_BITS-1:0]      w_wd;
    logic [LEVEL_BITS-1:0]      w_pk_sat;

    assign w_rd_addr = BAND_W'(w_bc);
    assign w_wa      = w_clr_we ? r_clr : r_band;
    assign w_wd      = w_clr_we ? '0 : w_pk_sat;

    always_ff @(posedge i_clk) begin
        if (w_launch) begin
            r_peak_q <= r_peak_mem[w_rd_addr];
            r_weight <= w_rom[w_rd_addr];
            r_band   <= w_rd_addr;
            r_sum    <= w_acc_nx;
            r_last   <= w_last;
        end
        if (w_clr_we || w_pk_we) r_peak_mem[w_wa] <= w_wd;
    end

    // level, peak hold, row
    logic [PROD_W-1:0]             r_prod;
    logic [PROD_W-14:0]            w_lvl_raw;
    logic [spbpf_pkg::SHOWN_W-1:0] r_level;
    logic [PW-1:0]                 w_lvl_dec;
    logic [PW-1:0]                 w_pk_ext;
    logic [PW-1:0]                 w_newpk;
    logic [spbpf_pkg::SHOWN_W-1:0] r_shown;
    logic signed [13:0]            w_hm23;
    logic signed [29:0]            w_rprod;
    logic signed [S_W-1:0]         r_s;
    logic signed [S_W-1:0]         w_sb;
    logic signed [Q_W-1:0]         r_q;
    logic signed [R_W-1:0]         w_row;
    logic signed [R_W-1:0]         w_row_c;
    logic signed [R_W-1:0]         w_row_o;

    assign w_lvl_raw = r_prod[PROD_W-1:13];
    assign w_lvl_dec = PW'(r_level) + PW'(r_decay);
    assign w_pk_ext  = PW'(r_peak_q);
    assign w_newpk   = (w_lvl_dec >= w_pk_ext) ? PW'(r_level) : (w_pk_ext - PW'(r_decay));
    assign w_pk_sat  = (w_newpk > PW'({LEVEL_BITS{1'b1}})) ? {LEVEL_BITS{1'b1}}
                                                            : LEVEL_BITS'(w_newpk);

    assign w_hm23  = $signed({2'b00, r_pane}) - 14'(spbpf_pkg::ROW_OFFSET);
    assign w_rprod = $signed({1'b0, r_shown}) * w_hm23;
    assign w_sb    = r_s + (r_s[S_W-1] ? S_W'(spbpf_pkg::ONE_Q14 - 1) : S_W'(0));
    assign w_row   = $signed({6'b0, r_pane}) - R_W'(r_q);
    assign w_row_c = (w_row < R_W'(spbpf_pkg::ROW_MIN)) ? R_W'(spbpf_pkg::ROW_CLAMPED) : w_row;
    assign w_row_o = w_row_c + R_W'(spbpf_pkg::ROW_SHIFT);

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            spbpf_pkg::ST_MUL:   r_prod <= PROD_W'(r_sum) * PROD_W'(r_weight);
            spbpf_pkg::ST_LEVEL: r_level <= (w_lvl_raw > (PROD_W - 13)'(spbpf_pkg::LEVEL_CLAMP))
                                            ? spbpf_pkg::SHOWN_W'(spbpf_pkg::LEVEL_CLAMP)
                                            : spbpf_pkg::SHOWN_W'(w_lvl_raw);
            spbpf_pkg::ST_PEAK:  r_shown <= spbpf_pkg::SHOWN_W'(w_newpk);
            spbpf_pkg::ST_PROD:  r_s <= S_W'(w_rprod) + S_W'(spbpf_pkg::ROW_BIAS);
            spbpf_pkg::ST_QUOT:  r_q <= Q_W'(w_sb >>> 14);
            default: ;
        endcase
    end

    // output register
    logic                          r_out_valid;
    logic [spbpf_pkg::IDX_W-1:0]   r_out_band;
    logic [spbpf_pkg::SHOWN_W-1:0] r_out_level;
    logic [spbpf_pkg::ROW_W-1:0]   r_out_row;
    logic                          r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_bar.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_band  <= spbpf_pkg::IDX_W'(r_band);
            r_out_level <= r_shown;
            r_out_row   <= spbpf_pkg::ROW_W'(w_row_o);
            r_out_last  <= r_last;
        end
    end

    assign o_bar.valid       = r_out_valid;
    assign o_bar.band_index  = r_out_band;
    assign o_bar.shown_level = r_out_level;
    assign o_bar.bar_top_row = r_out_row;
    assign o_bar.last_band   = r_out_last;

endmodule

// ----- rtl/spbpf_checker.sv -----
// Port-level checks for spectrum_bar_peak_falloff, attached by bind.
// Depends on spbpf_pkg.
module spbpf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [spbpf_pkg::IDX_W-1:0]     i_band_index,
    input logic [spbpf_pkg::SHOWN_W-1:0]   i_shown_level,
    input logic [spbpf_pkg::ROW_W-1:0]     i_bar_top_row,
    input logic                            i_last_band,
    input logic                            i_psel,
    input logic                            i_penable,
    input logic                            i_pwrite,
    input logic [spbpf_pkg::PADDR_W-1:0]   i_paddr,
    input logic [spbpf_pkg::PDATA_W-1:0]   i_pwdata,
    input logic [spbpf_pkg::PDATA_W-1:0]   i_prdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_band_index) &&
            $stable(i_shown_level) && $stable(i_bar_top_row) && $stable(i_last_band)))
        else $error("result changed while stalled");

    a_level_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_shown_level <= spbpf_pkg::SHOWN_W'(spbpf_pkg::LEVEL_CLAMP)))
        else $error("shown level above clamp");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite && i_paddr[3:2] == spbpf_pkg::REG_BAND_COUNT)
        ##1 (i_psel && !i_pwrite && i_paddr[3:2] == spbpf_pkg::REG_BAND_COUNT)
        |-> (i_prdata == spbpf_pkg::PDATA_W'($past(i_pwdata[spbpf_pkg::BCOUNT_W-1:0]))))
        else $error("band count readback mismatch");

endmodule

bind spectrum_bar_peak_falloff spbpf_checker u_spbpf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_bar.valid),
    .i_out_ready   (o_bar.ready),
    .i_band_index  (o_bar.band_index),
    .i_shown_level (o_bar.shown_level),
    .i_bar_top_row (o_bar.bar_top_row),
    .i_last_band   (o_bar.last_band),
    .i_psel        (psel),
    .i_penable     (penable),
    .i_pwrite      (pwrite),
    .i_paddr       (paddr),
    .i_pwdata      (pwdata),
    .i_prdata      (prdata)
);
